// ----- rtl/core/slsq_pkg.sv -----
// Shared types, codes and constants for the status LED sequencer.
`timescale 1ns / 1ps

package slsq_pkg;

    localparam int FLAG_BITS_DEF = 32;
    localparam int FLAG_WORD_W   = 32;

    localparam int MODE_W   = 3;
    localparam int OP_W     = 2;
    localparam int LEN_W    = 6;
    localparam int POS_W    = 7;
    localparam int HOLD_W   = 7;
    localparam int PERIOD_W = 6;
    localparam int LED_W    = 3;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_DATA_W = 7;

    // modes
    localparam logic [MODE_W-1:0] MODE_HW     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BURN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SHUT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPORT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIVE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EXIT   = 3'd5;

    // event kinds
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    // configuration register indexes
    localparam logic CFG_DIVE_PERIOD = 1'b0;
    localparam logic CFG_HOLD_LIMIT  = 1'b1;

    localparam logic [PERIOD_W-1:0] DIVE_PERIOD_RST = 6'd40;
    localparam logic [HOLD_W-1:0]   HOLD_LIMIT_RST  = 7'd80;
    localparam logic [LEN_W-1:0]    CODE_MAX        = 6'd62;
    localparam logic [HOLD_W-1:0]   HOLD_MAX        = 7'd127;

    // LED bit order in owner and level vectors: green, yellow, red
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [MODE_W-1:0]   return_mode;
        logic [1:0]          chase_phase;
        logic [POS_W-1:0]    bit_position;
        logic [LEN_W-1:0]    code_bits;
        logic [HOLD_W-1:0]   hold_ticks;
        logic [PERIOD_W-1:0] dive_ticks;
        logic [LED_W-1:0]    led_owner;
        logic [LED_W-1:0]    led_level;
    } t_ctl;

    typedef struct packed {
        logic [PERIOD_W-1:0] dive_period;
        logic [HOLD_W-1:0]   hold_limit;
    } t_cfg;

endpackage

// ----- rtl/core/slsq_step.sv -----
// Next-state logic of the sequencer for one event.
`timescale 1ns / 1ps

module slsq_step #(
    parameter int FLAG_BITS = slsq_pkg::FLAG_BITS_DEF,
    parameter int FLAG_USED = (FLAG_BITS < slsq_pkg::FLAG_WORD_W) ? FLAG_BITS
                                                                   : slsq_pkg::FLAG_WORD_W
) (
    input  slsq_pkg::t_ctl                   i_ctl,
    input  slsq_pkg::t_cfg                   i_cfg,
    input  logic [slsq_pkg::OP_W-1:0]        i_opcode,
    input  logic [slsq_pkg::MODE_W-1:0]      i_new_mode,
    input  logic [slsq_pkg::LEN_W-1:0]       i_code_length,
    input  logic [FLAG_USED-1:0]             i_warn_store,
    input  logic [FLAG_USED-1:0]             i_error_store,
    output slsq_pkg::t_ctl                   o_ctl,
    output logic                             o_load_flags
);
    import slsq_pkg::*;

    localparam int IDX_W = (FLAG_USED > 1) ? $clog2(FLAG_USED) : 1;

    function automatic t_ctl apply_mode(t_ctl s, logic [MODE_W-1:0] m);
        t_ctl r;
        r = s;
        case (m)
            MODE_HW: begin
                r.led_owner = 3'b000;
            end
            MODE_BURN: begin
                r.led_owner   = 3'b111;
                r.led_level   = 3'b100;
                r.chase_phase = 2'd0;
            end
            MODE_SHUT, MODE_REPORT: begin
                r.led_owner = 3'b111;
                r.led_level = 3'b000;
            end
            default: begin
                r.led_owner  = 3'b001;
                r.led_level  = 3'b001;
                r.dive_ticks = '0;
            end
        endcase
        r.mode = m;
        return r;
    endfunction

    function automatic t_ctl leave_report(t_ctl s);
        logic [MODE_W-1:0] t;
        t = (s.return_mode > MODE_DIVE) ? MODE_HW : s.return_mode;
        return apply_mode(s, t);
    endfunction

    logic [LEN_W-1:0]    pair;
    logic                odd;
    logic                err_flag;
    logic                warn_flag;
    logic [LEN_W-1:0]    code_p1;
    logic [HOLD_W-1:0]   hold_inc;
    logic [PERIOD_W:0]   dive_inc;
    t_ctl                n;

    assign pair    = i_ctl.bit_position[POS_W-1:1];
    assign odd     = i_ctl.bit_position[0];
    assign code_p1 = i_ctl.code_bits + LEN_W'(1);
    assign hold_inc = (i_ctl.hold_ticks < HOLD_MAX) ? i_ctl.hold_ticks + HOLD_W'(1)
                                                    : i_ctl.hold_ticks;
    assign dive_inc = {1'b0, i_ctl.dive_ticks} + (PERIOD_W + 1)'(1);

    // flags past the stored width read as zero
    always_comb begin
        err_flag  = 1'b0;
        warn_flag = 1'b0;
        if ({1'b0, pair} < (LEN_W + 1)'(FLAG_USED)) begin
            err_flag  = i_error_store[pair[IDX_W-1:0]];
            warn_flag = i_warn_store[pair[IDX_W-1:0]];
        end
    end

    always_comb begin
        n            = i_ctl;
        o_load_flags = 1'b0;
        case (i_opcode)
            OP_TICK: begin
                case (i_ctl.mode)
                    MODE_BURN: begin
                        case (i_ctl.chase_phase)
                            2'd0: begin
                                n.led_owner    = i_ctl.led_owner | 3'b110;
                                n.led_level[1] = 1'b1;
                                n.led_level[2] = 1'b0;
                                n.chase_phase  = 2'd1;
                            end
                            2'd1: begin
                                n.led_owner    = i_ctl.led_owner | 3'b011;
                                n.led_level[0] = 1'b1;
                                n.led_level[1] = 1'b0;
                                n.chase_phase  = 2'd2;
                            end
                            default: begin
                                n.led_owner    = i_ctl.led_owner | 3'b101;
                                n.led_level[2] = 1'b1;
                                n.led_level[0] = 1'b0;
                                n.chase_phase  = 2'd0;
                            end
                        endcase
                    end
                    MODE_REPORT: begin
                        if (pair < i_ctl.code_bits) begin
                            if (odd) begin
                                n.led_owner[1] = 1'b1;
                                n.led_level[1] = 1'b1;
                                if (err_flag) begin
                                    n.led_owner[2] = 1'b1;
                                    n.led_level[2] = 1'b1;
                                end
                                if (warn_flag) begin
                                    n.led_owner[0] = 1'b1;
                                    n.led_level[0] = 1'b1;
                                end
                            end else begin
                                n.led_owner = 3'b111;
                                n.led_level = 3'b000;
                            end
                            n.bit_position = i_ctl.bit_position + POS_W'(1);
                        end else if (pair == i_ctl.code_bits) begin
                            if (odd) begin
                                n.led_owner    = 3'b111;
                                n.led_level    = 3'b000;
                                n.bit_position = i_ctl.bit_position + POS_W'(1);
                            end else begin
                                // summary: red if any error flag, yellow always
                                if (|i_error_store) begin
                                    n.led_owner[2] = 1'b1;
                                    n.led_level[2] = 1'b1;
                                end
                                n.led_owner[1] = 1'b1;
                                n.led_level[1] = 1'b1;
                                n.bit_position = {code_p1, 1'b0};
                                n.hold_ticks   = '0;
                            end
                        end else begin
                            n.hold_ticks = hold_inc;
                            if (hold_inc > i_cfg.hold_limit) begin
                                n = leave_report(n);
                            end
                        end
                    end
                    MODE_DIVE: begin
                        n.led_owner[0] = 1'b1;
                        n.led_level[0] = (i_ctl.dive_ticks == '0);
                        n.dive_ticks   = (dive_inc >= {1'b0, i_cfg.dive_period})
                                         ? '0 : dive_inc[PERIOD_W-1:0];
                    end
                    MODE_EXIT: begin
                        n = apply_mode(i_ctl, MODE_HW);
                    end
                    default: begin
                    end
                endcase
            end
            OP_SET: begin
                if (i_new_mode == MODE_EXIT) begin
                    n = leave_report(i_ctl);
                end else if (i_new_mode < MODE_EXIT) begin
                    if (i_ctl.mode == MODE_REPORT) begin
                        n.return_mode = i_new_mode;
                    end else begin
                        n = apply_mode(i_ctl, i_new_mode);
                    end
                end
            end
            OP_REPORT: begin
                o_load_flags   = 1'b1;
                n.code_bits    = (i_code_length > CODE_MAX) ? CODE_MAX : i_code_length;
                n.bit_position = '0;
                if (i_ctl.mode == MODE_REPORT) begin
                    // report mode is re-entered once the new one ends
                    n.return_mode = MODE_REPORT;
                end else begin
                    n.return_mode = i_ctl.mode;
                    n = apply_mode(n, MODE_REPORT);
                end
            end
            default: begin
            end
        endcase
        o_ctl = n;
    end

endmodule

// ----- rtl/core/slsq_out_stage.sv -----
// Result register with valid flag between the sequencer and its consumer.
`timescale 1ns / 1ps

module slsq_out_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [slsq_pkg::OUT_DATA_W-1:0]   i_data,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [slsq_pkg::OUT_DATA_W-1:0]   o_data,
    output logic                              o_can_load
);
    import slsq_pkg::*;

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;

    // free when empty or when the held result leaves this cycle
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/core/status_led_sequencer_unit.sv -----
// Top level of the status LED sequencer: state, configuration and result stage.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser opcode, tdata event fields
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata LED levels, owners, mode
//  cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One event per cycle unless stalled; the result register loads at the transfer edge.
// State and result register update together at the input transfer edge.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// Synchronous active-low reset; no clearing pass, all state is in flip-flops.
// Configuration writes are always taken.
`timescale 1ns / 1ps

module status_led_sequencer_unit #(
    parameter int FLAG_BITS = slsq_pkg::FLAG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] opcode
    input  logic [slsq_pkg::OP_W-1:0]         s_axis_tuser,
    // [2:0] new_mode, [8:3] code_length, [40:9] warn_bits, [72:41] error_bits, rest zero
    input  logic [slsq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] green_on, [1] yellow_on, [2] red_on, [3] green_owner, [4] yellow_owner,
    // [5] red_owner, [8:6] current_mode, rest zero
    output logic [slsq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [slsq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import slsq_pkg::*;

    localparam int FLAG_USED = (FLAG_BITS < FLAG_WORD_W) ? FLAG_BITS : FLAG_WORD_W;

    t_ctl                r_ctl;
    t_ctl                n_ctl;
    t_cfg                r_cfg;
    logic [FLAG_USED-1:0] r_warn_store;
    logic [FLAG_USED-1:0] r_error_store;
    logic                load_flags;
    logic                can_load;
    logic                in_fire;

    logic [MODE_W-1:0]      in_new_mode;
    logic [LEN_W-1:0]       in_code_length;
    logic [FLAG_WORD_W-1:0] in_warn;
    logic [FLAG_WORD_W-1:0] in_error;
    logic [OUT_DATA_W-1:0]  res_data;

    assign in_new_mode    = s_axis_tdata[2:0];
    assign in_code_length = s_axis_tdata[8:3];
    assign in_warn        = s_axis_tdata[40:9];
    assign in_error       = s_axis_tdata[72:41];

    assign s_axis_tready = can_load;
    assign in_fire       = s_axis_tvalid && can_load;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dive_period <= DIVE_PERIOD_RST;
            r_cfg.hold_limit  <= HOLD_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIVE_PERIOD: r_cfg.dive_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_HOLD_LIMIT:  r_cfg.hold_limit  <= i_cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    slsq_step #(
        .FLAG_BITS (FLAG_BITS),
        .FLAG_USED (FLAG_USED)
    ) u_step (
        .i_ctl         (r_ctl),
        .i_cfg         (r_cfg),
        .i_opcode      (s_axis_tuser),
        .i_new_mode    (in_new_mode),
        .i_code_length (in_code_length),
        .i_warn_store  (r_warn_store),
        .i_error_store (r_error_store),
        .o_ctl         (n_ctl),
        .o_load_flags  (load_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl         <= '0;
            r_warn_store  <= '0;
            r_error_store <= '0;
        end else if (in_fire) begin
            r_ctl <= n_ctl;
            if (load_flags) begin
                r_warn_store  <= in_warn[FLAG_USED-1:0];
                r_error_store <= in_error[FLAG_USED-1:0];
            end
        end
    end

    assign res_data = {(OUT_DATA_W - MODE_W - 2 * LED_W)'(0),
                       n_ctl.mode, n_ctl.led_owner, n_ctl.led_level};

    slsq_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_fire),
        .i_data     (res_data),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (m_axis_tdata),
        .o_can_load (can_load)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> m_axis_tvalid)
        else $error("accepted event produced no result");

    a_report_entered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tuser == OP_REPORT) |=> r_ctl.mode == MODE_REPORT)
        else $error("report request did not enter report mode");

    a_hw_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.mode == MODE_HW) |-> (r_ctl.led_owner == 3'b000))
        else $error("hardware mode with a processor-driven LED");

    a_shut_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.mode == MODE_SHUT) |-> (r_ctl.led_owner == 3'b111 && r_ctl.led_level == 3'b000))
        else $error("shutdown mode with an LED lit or released");

endmodule
